### src/magnetic_pendulum_basin_solver_core_macros.svh
// assertion helpers for the pendulum basin solver
`ifndef MAGNETIC_PENDULUM_BASIN_SOLVER_CORE_MACROS_SVH
`define MAGNETIC_PENDULUM_BASIN_SOLVER_CORE_MACROS_SVH
`ifndef SYNTH
`define MPBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MPBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPBS_ASSERT(lbl, clk, rst, prop, msg)
`define MPBS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/mpbs_pkg.sv
`timescale 1ns / 1ps
package mpbs_pkg;

   localparam int MAX_MAGNETS = 8;
   localparam int SLOT_BITS   = 3;
   localparam int COUNT_BITS  = 4;
   localparam int WORD_BITS   = 48;
   localparam int REG_BITS    = 47;
   localparam int FRAC_BITS   = 32;
   localparam int STEP_BITS   = 17;
   localparam int LIMIT_BITS  = 16;
   localparam int CSR_BITS    = 3;
   localparam int CNT_BITS    = 7;
   localparam int MUL_LAST    = 4;
   localparam int DIV_STEPS   = REG_BITS + FRAC_BITS + 1;
   localparam int SQRT_STEPS  = 64;

   localparam logic [63:0] MAG_CAP = 64'h4000_0000_0000_0000;
   localparam logic [63:0] Q_MAX   = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN_MAG = 64'h0000_8000_0000_0000;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_RUN  = 1'b1;

   typedef enum logic [1:0] {
      OP_MUL  = 2'd0,
      OP_DIV  = 2'd1,
      OP_SQRT = 2'd2
   } arith_op_type;

   typedef enum logic [CSR_BITS-1:0] {
      REG_DAMPING   = 3'd0,
      REG_SPRING    = 3'd1,
      REG_STEP_SIZE = 3'd2,
      REG_STRENGTH  = 3'd3,
      REG_COUNT     = 3'd4,
      REG_MAX_STEPS = 3'd5,
      REG_RADIUS    = 3'd6,
      REG_HEIGHT    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                        func;
      logic [SLOT_BITS-1:0]        magnet_slot;
      logic signed [WORD_BITS-1:0] x_coord;
      logic signed [WORD_BITS-1:0] y_coord;
   } req_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0]       captured_magnet;
      logic [STEP_BITS-1:0]        steps_taken;
      logic signed [WORD_BITS-1:0] final_x;
      logic signed [WORD_BITS-1:0] final_y;
   } rsp_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
      logic [127:0] opd_a;
      logic [63:0]  opd_b;
   } arith_req_type;

   typedef struct packed {
      logic         busy;
      logic         done;
      logic [127:0] value;
   } arith_rsp_type;

   // product rounded half up to the fraction point, capped
   function automatic logic [63:0] round_q(input logic [127:0] p);
      logic [127:0] s;
      logic [63:0]  r;
      s = p + (128'd1 << (FRAC_BITS - 1));
      r = s[FRAC_BITS +: 64];
      if ((s >> (FRAC_BITS + 64)) != '0 || r > MAG_CAP) begin
         return MAG_CAP;
      end
      return r;
   endfunction

   // sign and magnitude back to a saturated word
   function automatic logic signed [WORD_BITS-1:0] sat_word(input logic neg,
                                                            input logic [63:0] m);
      logic [63:0] v;
      v = ~m + 64'd1;
      if (!neg) begin
         if (m > Q_MAX) return Q_MAX[WORD_BITS-1:0];
         return m[WORD_BITS-1:0];
      end
      if (m > Q_MIN_MAG) return Q_MIN_MAG[WORD_BITS-1:0];
      return v[WORD_BITS-1:0];
   endfunction

   function automatic logic signed [WORD_BITS-1:0] add_sat(
         input logic signed [WORD_BITS-1:0] a,
         input logic signed [WORD_BITS-1:0] b,
         input logic sub);
      logic [WORD_BITS:0] s;
      if (sub) s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
      else     s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
      if (s[WORD_BITS] != s[WORD_BITS-1]) begin
         return s[WORD_BITS] ? Q_MIN_MAG[WORD_BITS-1:0] : Q_MAX[WORD_BITS-1:0];
      end
      return s[WORD_BITS-1:0];
   endfunction

   function automatic logic [63:0] mag_of(input logic signed [WORD_BITS:0] a);
      logic [WORD_BITS:0] m;
      m = a[WORD_BITS] ? (~a + 1'b1) : a;
      return 64'(m);
   endfunction

endpackage

### src/magnetic_pendulum_basin_solver_core.sv
// Magnetic pendulum basin solver. Load magnet positions with func 0 words (one slot each,
// no result), then send func 1 words with a start point: the pendulum is integrated from
// rest with semi-implicit Euler steps in signed Q16.32 until it comes within the capture
// radius of a magnet or exceeds max_steps, and one result word gives the nearest magnet
// (1-based, 0 when the step limit ends the run), the step count and the final position.
// One run at a time. All multiplies, divides and square roots go through one shared
// iterative unit. Registers are to be written through the csr port only while no run is
// in progress; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "magnetic_pendulum_basin_solver_core_macros.svh"
module magnetic_pendulum_basin_solver_core import mpbs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [CSR_BITS-1:0] csr_index,
   input  logic [REG_BITS-1:0] csr_wdata
);

   typedef enum logic [29:0] {
      S_IDLE  = 30'd1 << 0,
      S_WAIT  = 30'd1 << 1,
      S_DONE  = 30'd1 << 2,
      S_C0    = 30'd1 << 3,
      S_C1    = 30'd1 << 4,
      S_C2    = 30'd1 << 5,
      S_C3    = 30'd1 << 6,
      S_C4    = 30'd1 << 7,
      S_C5    = 30'd1 << 8,
      S_I0    = 30'd1 << 9,
      S_I1    = 30'd1 << 10,
      S_I2    = 30'd1 << 11,
      S_M0    = 30'd1 << 12,
      S_M1    = 30'd1 << 13,
      S_M2    = 30'd1 << 14,
      S_M3    = 30'd1 << 15,
      S_M4    = 30'd1 << 16,
      S_M5    = 30'd1 << 17,
      S_M6    = 30'd1 << 18,
      S_M7    = 30'd1 << 19,
      S_M8    = 30'd1 << 20,
      S_M9    = 30'd1 << 21,
      S_MNEXT = 30'd1 << 22,
      S_D0    = 30'd1 << 23,
      S_D1    = 30'd1 << 24,
      S_D2    = 30'd1 << 25,
      S_D3    = 30'd1 << 26,
      S_D4    = 30'd1 << 27,
      S_D5    = 30'd1 << 28,
      S_D6    = 30'd1 << 29
   } state_type;

   // configuration registers
   logic [REG_BITS-1:0]   damping_ff, spring_ff, step_size_ff, strength_ff;
   logic [REG_BITS-1:0]   radius_ff, height_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [LIMIT_BITS-1:0] max_steps_ff;

   // sequencer and run state
   state_type state_ff, state_in, ret_ff, ret_in;
   logic [SLOT_BITS-1:0]        idx_ff, idx_in;
   logic                        neg_ff, neg_in;
   logic signed [WORD_BITS-1:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic signed [WORD_BITS-1:0] fx_ff, fy_ff, ax_ff, ay_ff, tmp_ff;
   logic signed [WORD_BITS:0]   dx_ff, dy_ff;
   logic [STEP_BITS-1:0]        step_ff;
   logic [127:0]                acc_ff, lim_ff, bd_ff;
   logic [63:0]                 root_ff, coef_ff;
   logic [COUNT_BITS-1:0]       best_ff;
   logic                        hit_ff;
   rsp_type                     rsp_ff;
   logic                        rsp_valid_ff;

   arith_req_type arith_req;
   arith_rsp_type arith_rsp;

   logic [2*WORD_BITS-1:0]      ram_rdata;
   logic                        ram_we;
   logic signed [WORD_BITS-1:0] mag_x, mag_y;
   logic signed [WORD_BITS:0]   dxc, dyc;
   logic [COUNT_BITS-1:0]       n_act;
   logic                        more, over, load_out;
   logic [63:0]                 pq;
   logic signed [WORD_BITS-1:0] sfin;
   logic [127:0]                dsum;
   logic [127:0]                div_num;

   // magnet table: x in the upper half, y in the lower
   assign ram_we = req_valid && req_ready && (req_data.func == FUNC_LOAD);

   mpbs_ram #(
      .WIDTH (2 * WORD_BITS),
      .DEPTH (MAX_MAGNETS)
   ) u_magnet_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_data.magnet_slot),
      .wr_data ({req_data.x_coord, req_data.y_coord}),
      .rd_addr (idx_in),
      .rd_data (ram_rdata)
   );

   mpbs_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .arith_req (arith_req),
      .arith_rsp (arith_rsp)
   );

   assign mag_x = ram_rdata[2*WORD_BITS-1:WORD_BITS];
   assign mag_y = ram_rdata[WORD_BITS-1:0];
   // offsets from the pendulum to the magnet currently read
   assign dxc = {mag_x[WORD_BITS-1], mag_x} - {pos_x_ff[WORD_BITS-1], pos_x_ff};
   assign dyc = {mag_y[WORD_BITS-1], mag_y} - {pos_y_ff[WORD_BITS-1], pos_y_ff};

   assign n_act = (count_ff > COUNT_BITS'(MAX_MAGNETS)) ? COUNT_BITS'(MAX_MAGNETS) : count_ff;
   assign more  = ({1'b0, idx_ff} + 4'd1) < n_act;
   assign over  = step_ff > {1'b0, max_steps_ff};

   // rounded product and its signed, saturated form
   assign pq      = round_q(arith_rsp.value);
   assign sfin    = sat_word(neg_ff, pq);
   assign dsum    = acc_ff + arith_rsp.value;
   assign div_num = 128'(strength_ff) << FRAC_BITS;

   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         damping_ff   <= REG_BITS'(858993459);
         spring_ff    <= REG_BITS'(429496730);
         step_size_ff <= REG_BITS'(12271335);
         strength_ff  <= REG_BITS'(64'd4294967296000);
         count_ff     <= COUNT_BITS'(3);
         max_steps_ff <= LIMIT_BITS'(10000);
         radius_ff    <= REG_BITS'(4294967);
         height_ff    <= REG_BITS'(1073741824);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            REG_DAMPING:   damping_ff   <= csr_wdata;
            REG_SPRING:    spring_ff    <= csr_wdata;
            REG_STEP_SIZE: step_size_ff <= csr_wdata;
            REG_STRENGTH:  strength_ff  <= csr_wdata;
            REG_COUNT:     count_ff     <= csr_wdata[COUNT_BITS-1:0];
            REG_MAX_STEPS: max_steps_ff <= csr_wdata[LIMIT_BITS-1:0];
            REG_RADIUS:    radius_ff    <= csr_wdata;
            REG_HEIGHT:    height_ff    <= csr_wdata;
         endcase
      end
   end

   // sequencer: most states consume the last result and issue the next operation
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      idx_in    = idx_ff;
      neg_in    = 1'b0;
      arith_req = '0;
      arith_req.op = OP_MUL;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_data.func == FUNC_RUN) state_in = S_C0;
         end
         S_WAIT: begin
            if (arith_rsp.done) state_in = ret_ff;
         end
         S_DONE: begin
            if (load_out) state_in = S_IDLE;
         end
         // capture check
         S_C0: begin
            idx_in = '0;
            if (over) begin
               state_in = S_DONE;
            end else if (n_act == '0) begin
               state_in = S_I0;
            end else begin
               arith_req.start = 1'b1;
               arith_req.opd_a = 128'(radius_ff);
               arith_req.opd_b = 64'(radius_ff);
               state_in = S_WAIT;
               ret_in   = S_C1;
            end
         end
         S_C1: state_in = S_C4;
         S_C4: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dxc));
            arith_req.opd_b = mag_of(dxc);
            state_in = S_WAIT;
            ret_in   = S_C2;
         end
         S_C2: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dy_ff));
            arith_req.opd_b = mag_of(dy_ff);
            state_in = S_WAIT;
            ret_in   = S_C3;
         end
         S_C3: begin
            if (more) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_C4;
            end else begin
               state_in = S_C5;
            end
         end
         S_C5: state_in = hit_ff ? S_DONE : S_I0;
         // position update
         S_I0: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({vel_x_ff[WORD_BITS-1], vel_x_ff}));
            arith_req.opd_b = 64'(step_size_ff);
            neg_in   = vel_x_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_I1;
         end
         S_I1: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({vel_y_ff[WORD_BITS-1], vel_y_ff}));
            arith_req.opd_b = 64'(step_size_ff);
            neg_in   = vel_y_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_I2;
         end
         S_I2: begin
            idx_in   = '0;
            state_in = (n_act == '0) ? S_D0 : S_M0;
         end
         // attraction of one magnet
         S_M0: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dxc));
            arith_req.opd_b = mag_of(dxc);
            state_in = S_WAIT;
            ret_in   = S_M1;
         end
         S_M1: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dy_ff));
            arith_req.opd_b = mag_of(dy_ff);
            state_in = S_WAIT;
            ret_in   = S_M2;
         end
         S_M2: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(height_ff);
            arith_req.opd_b = 64'(height_ff);
            state_in = S_WAIT;
            ret_in   = S_M3;
         end
         S_M3: begin
            arith_req.start = 1'b1;
            arith_req.op    = OP_SQRT;
            arith_req.opd_a = dsum;
            state_in = S_WAIT;
            ret_in   = S_M4;
         end
         S_M4: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(arith_rsp.value[63:0]);
            arith_req.opd_b = arith_rsp.value[63:0];
            state_in = S_WAIT;
            ret_in   = S_M5;
         end
         S_M5: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(root_ff);
            arith_req.opd_b = pq;
            state_in = S_WAIT;
            ret_in   = S_M6;
         end
         S_M6: begin
            // a magnet at zero cube distance pulls nothing
            if (pq == '0) begin
               state_in = S_MNEXT;
            end else begin
               arith_req.start = 1'b1;
               arith_req.op    = OP_DIV;
               arith_req.opd_a = div_num;
               arith_req.opd_b = pq;
               state_in = S_WAIT;
               ret_in   = S_M7;
            end
         end
         S_M7: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dx_ff));
            arith_req.opd_b = arith_rsp.value[63:0];
            neg_in   = dx_ff[WORD_BITS];
            state_in = S_WAIT;
            ret_in   = S_M8;
         end
         S_M8: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of(dy_ff));
            arith_req.opd_b = coef_ff;
            neg_in   = dy_ff[WORD_BITS];
            state_in = S_WAIT;
            ret_in   = S_M9;
         end
         S_M9: state_in = S_MNEXT;
         S_MNEXT: begin
            if (more) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_M0;
            end else begin
               state_in = S_D0;
            end
         end
         // damping, spring and velocity update
         S_D0: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({vel_x_ff[WORD_BITS-1], vel_x_ff}));
            arith_req.opd_b = 64'(damping_ff);
            neg_in   = vel_x_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D1;
         end
         S_D1: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({pos_x_ff[WORD_BITS-1], pos_x_ff}));
            arith_req.opd_b = 64'(spring_ff);
            neg_in   = pos_x_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D2;
         end
         S_D2: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({vel_y_ff[WORD_BITS-1], vel_y_ff}));
            arith_req.opd_b = 64'(damping_ff);
            neg_in   = vel_y_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D3;
         end
         S_D3: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({pos_y_ff[WORD_BITS-1], pos_y_ff}));
            arith_req.opd_b = 64'(spring_ff);
            neg_in   = pos_y_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D4;
         end
         S_D4: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({ax_ff[WORD_BITS-1], ax_ff}));
            arith_req.opd_b = 64'(step_size_ff);
            neg_in   = ax_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D5;
         end
         S_D5: begin
            arith_req.start = 1'b1;
            arith_req.opd_a = 128'(mag_of({ay_ff[WORD_BITS-1], ay_ff}));
            arith_req.opd_b = 64'(step_size_ff);
            neg_in   = ay_ff[WORD_BITS-1];
            state_in = S_WAIT;
            ret_in   = S_D6;
         end
         S_D6: state_in = S_C0;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ret_ff       <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
         if (load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // run datapath
   always_ff @(posedge clock) begin
      if (arith_req.start) neg_ff <= neg_in;
      if (load_out) begin
         rsp_ff.captured_magnet <= hit_ff ? best_ff : '0;
         rsp_ff.steps_taken     <= step_ff;
         rsp_ff.final_x         <= pos_x_ff;
         rsp_ff.final_y         <= pos_y_ff;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_data.func == FUNC_RUN) begin
               pos_x_ff <= req_data.x_coord;
               pos_y_ff <= req_data.y_coord;
               vel_x_ff <= '0;
               vel_y_ff <= '0;
               step_ff  <= '0;
            end
         end
         S_C0: hit_ff <= 1'b0;
         S_C1: lim_ff <= arith_rsp.value;
         S_C4: begin
            dx_ff <= dxc;
            dy_ff <= dyc;
         end
         S_C2: acc_ff <= arith_rsp.value;
         S_C3: begin
            if (dsum < lim_ff) hit_ff <= 1'b1;
            // nearest by squared distance, lowest slot on a tie
            if (idx_ff == '0 || dsum < bd_ff) begin
               bd_ff   <= dsum;
               best_ff <= {1'b0, idx_ff} + 4'd1;
            end
         end
         S_I1: pos_x_ff <= add_sat(pos_x_ff, sfin, 1'b0);
         S_I2: begin
            pos_y_ff <= add_sat(pos_y_ff, sfin, 1'b0);
            fx_ff    <= '0;
            fy_ff    <= '0;
         end
         S_M0: begin
            dx_ff <= dxc;
            dy_ff <= dyc;
         end
         S_M1: acc_ff <= arith_rsp.value;
         S_M2: acc_ff <= dsum;
         S_M4: root_ff <= arith_rsp.value[63:0];
         S_M7: coef_ff <= arith_rsp.value[63:0];
         S_M8: fx_ff <= add_sat(fx_ff, sfin, 1'b0);
         S_M9: fy_ff <= add_sat(fy_ff, sfin, 1'b0);
         S_D1: tmp_ff <= add_sat(fx_ff, sfin, 1'b1);
         S_D2: ax_ff <= add_sat(tmp_ff, sfin, 1'b1);
         S_D3: tmp_ff <= add_sat(fy_ff, sfin, 1'b1);
         S_D4: ay_ff <= add_sat(tmp_ff, sfin, 1'b1);
         S_D5: vel_x_ff <= add_sat(vel_x_ff, sfin, 1'b0);
         S_D6: begin
            vel_y_ff <= add_sat(vel_y_ff, sfin, 1'b0);
            step_ff  <= step_ff + 1'b1;
         end
         default: begin
            hit_ff <= hit_ff;
         end
      endcase
   end

   // reset leaves the sequencer idle with no word pending
   `MPBS_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (state_ff == S_IDLE && !rsp_valid_ff), "not idle after reset")
   // the shared unit is never restarted mid-operation
   `MPBS_ASSERT(a_arith_free, clock, reset, arith_req.start |-> !arith_rsp.busy, "arith unit restarted while busy")
   // a run never reports more than one step past the limit
   `MPBS_ASSERT(a_step_bound, clock, reset, rsp_valid_ff |-> (18'(rsp_ff.steps_taken) <= 18'(max_steps_ff) + 18'd1), "step count past limit")
   // the reported magnet is one of those in use
   `MPBS_ASSERT(a_magnet_bound, clock, reset, rsp_valid_ff |-> (rsp_ff.captured_magnet <= n_act), "magnet number out of range")

endmodule

### src/mpbs_ram.sv
`timescale 1ns / 1ps
module mpbs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### src/mpbs_arith.sv
`timescale 1ns / 1ps
module mpbs_arith import mpbs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  arith_req_type arith_req,
   output arith_rsp_type arith_rsp
);

   arith_op_type        op_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [127:0]        opa_ff;
   logic [63:0]         opb_ff;
   logic [127:0]        acc_ff;
   logic [63:0]         pp_ff;
   logic [1:0]          sh_ff;
   logic [65:0]         rem_ff;
   logic [63:0]         res_ff;

   logic          last;
   logic [31:0]   a_half, b_half;
   logic [63:0]   prod;
   logic [127:0]  pp_shift;
   logic [65:0]   div_rem_sh, div_rem_nx;
   logic          div_ge;
   logic [64:0]   q_sh;
   logic [63:0]   q_nx;
   logic [65:0]   sq_rem_sh, sq_trial, sq_rem_nx;
   logic          sq_ge;

   always_comb begin
      unique case (op_ff)
         OP_MUL:  last = (cnt_ff == CNT_BITS'(MUL_LAST));
         OP_DIV:  last = (cnt_ff == CNT_BITS'(DIV_STEPS - 1));
         OP_SQRT: last = (cnt_ff == CNT_BITS'(SQRT_STEPS - 1));
         default: last = 1'b1;
      endcase
   end

   // 64x64 product from four 32x32 partial products
   assign a_half = cnt_ff[1] ? opa_ff[63:32] : opa_ff[31:0];
   assign b_half = cnt_ff[0] ? opb_ff[63:32] : opb_ff[31:0];
   assign prod   = a_half * b_half;

   always_comb begin
      unique case (sh_ff)
         2'd0:    pp_shift = {64'd0, pp_ff};
         2'd1:    pp_shift = {32'd0, pp_ff, 32'd0};
         default: pp_shift = {pp_ff, 64'd0};
      endcase
   end

   // restoring divide, one quotient bit a cycle
   assign div_rem_sh = {rem_ff[64:0], opa_ff[DIV_STEPS-1]};
   assign div_ge     = div_rem_sh >= {2'b00, opb_ff};
   assign div_rem_nx = div_ge ? div_rem_sh - {2'b00, opb_ff} : div_rem_sh;
   assign q_sh       = {res_ff, div_ge};
   assign q_nx       = (q_sh > {1'b0, MAG_CAP}) ? MAG_CAP : q_sh[63:0];

   // digit-by-digit square root, one root bit a cycle
   assign sq_rem_sh = {rem_ff[63:0], opa_ff[127:126]};
   assign sq_trial  = {res_ff, 2'b01};
   assign sq_ge     = sq_rem_sh >= sq_trial;
   assign sq_rem_nx = sq_ge ? sq_rem_sh - sq_trial : sq_rem_sh;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (arith_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            if (last) busy_ff <= 1'b0;
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (arith_req.start) begin
         op_ff  <= arith_req.op;
         opa_ff <= arith_req.opd_a;
         opb_ff <= arith_req.opd_b;
         acc_ff <= '0;
         pp_ff  <= '0;
         sh_ff  <= '0;
         rem_ff <= '0;
         res_ff <= '0;
      end else if (busy_ff) begin
         unique case (op_ff)
            OP_MUL: begin
               pp_ff  <= prod;
               sh_ff  <= {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
               acc_ff <= acc_ff + pp_shift;
            end
            OP_DIV: begin
               opa_ff <= opa_ff << 1;
               rem_ff <= div_rem_nx;
               res_ff <= q_nx;
            end
            OP_SQRT: begin
               opa_ff <= opa_ff << 2;
               rem_ff <= sq_rem_nx;
               res_ff <= sq_ge ? {res_ff[62:0], 1'b1} : {res_ff[62:0], 1'b0};
            end
            default: begin
               res_ff <= res_ff;
            end
         endcase
      end
   end

   assign arith_rsp.busy  = busy_ff;
   assign arith_rsp.done  = done_ff;
   assign arith_rsp.value = (op_ff == OP_MUL) ? acc_ff : {64'd0, res_ff};

endmodule
